FILE: src/atcr_pkg.sv
// Shared types, constants and helpers for the tile collision resolver.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package atcr_pkg;

    localparam int POS_BITS  = 24;
    localparam int FRAC_BITS = 8;
    localparam int VEL_BITS  = 16;
    localparam int CFG_BITS  = 8;
    localparam int SIZE_BITS = POS_BITS - 1;
    // Working width for box edges, depths and doubled centres.
    localparam int CALC_W    = POS_BITS + 4;

    localparam int IN_RAW_BITS   = 4 * POS_BITS + 2 * VEL_BITS + 2 * SIZE_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 2 * POS_BITS + 2 * VEL_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic       CMD_LOAD = 1'b0;
    localparam logic       CMD_TILE = 1'b1;

    localparam logic [1:0] HIT_NONE  = 2'd0;
    localparam logic [1:0] HIT_HORIZ = 2'd1;
    localparam logic [1:0] HIT_VERT  = 2'd2;

    localparam logic [1:0] REG_ENTITY_WIDTH  = 2'd0;
    localparam logic [1:0] REG_ENTITY_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BOUNCE_GAIN   = 2'd2;
    localparam logic [1:0] REG_WALL_GAP      = 2'd3;

    localparam logic [CFG_BITS-1:0] RST_ENTITY_WIDTH  = CFG_BITS'(32);
    localparam logic [CFG_BITS-1:0] RST_ENTITY_HEIGHT = CFG_BITS'(64);
    localparam logic [CFG_BITS-1:0] RST_BOUNCE_GAIN   = CFG_BITS'(77);
    localparam logic [CFG_BITS-1:0] RST_WALL_GAP      = CFG_BITS'(3);

    typedef logic signed [POS_BITS-1:0] pos_t;
    typedef logic signed [VEL_BITS-1:0] vel_t;
    typedef logic [SIZE_BITS-1:0]       size_t;
    typedef logic signed [CALC_W-1:0]   calc_t;

    localparam calc_t POS_MAX = calc_t'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
    localparam calc_t POS_MIN = calc_t'(-(64'sd1 <<< (POS_BITS - 1)));

    typedef struct packed {
        logic [CFG_BITS-1:0] entity_width;
        logic [CFG_BITS-1:0] entity_height;
        logic [CFG_BITS-1:0] bounce_gain;
        logic [CFG_BITS-1:0] wall_gap;
    } cfg_t;

    typedef struct packed {
        pos_t cur_x;
        pos_t cur_y;
        vel_t cur_vx;
        vel_t cur_vy;
        pos_t start_x;
        pos_t start_y;
    } state_t;

    typedef struct packed {
        logic  cmd;
        pos_t  entity_x;
        pos_t  entity_y;
        vel_t  speed_x;
        vel_t  speed_y;
        pos_t  tile_left;
        pos_t  tile_top;
        size_t tile_width;
        size_t tile_height;
    } item_t;

    function automatic pos_t sat_pos(input calc_t v);
        pos_t r;
        if (v > POS_MAX) begin
            r = POS_MAX[POS_BITS-1:0];
        end else if (v < POS_MIN) begin
            r = POS_MIN[POS_BITS-1:0];
        end else begin
            r = v[POS_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/aabb_tile_collision_resolve.sv
// Top level of the tile collision resolver: request and result registers,
// entity state and configuration registers. Uses atcr_pkg and atcr_resolve.
//
// One entity is resolved against a stream of tiles. A load request sets the
// entity position and velocity; each tile request tests the entity box against
// one tile and pushes the entity out sideways or turns its velocity round. Every
// request gives exactly one result showing the state after it, with the hit kind
// on m_tuser. A request is accepted in every cycle while results are taken, and
// it waits in the request register; the state update, combinational because
// each tile test starts from the position left by the previous one, is then
// written to the state register. Configuration must be written only while no
// request is in flight; the block itself does not enforce this.
`default_nettype none

module aabb_tile_collision_resolve
    import atcr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // tdata: entity_x, entity_y, speed_x, speed_y, tile_left, tile_top,
    //        tile_width, tile_height, zero pad
    input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
    // tuser: cmd
    input  wire logic                     s_tuser,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // tdata: out_x, out_y, out_vx, out_vy
    output logic [OUT_DATA_BITS-1:0]      m_tdata,
    // tuser: hit
    output logic [1:0]                    m_tuser,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    input  wire logic                     cfg_wr_en,
    input  wire logic [1:0]               cfg_addr,
    input  wire logic [CFG_BITS-1:0]      cfg_wdata
);

    item_t      item_in;
    item_t      item_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       advance;
    state_t     state_reg;
    state_t     state_next;
    cfg_t       cfg_reg;
    logic [1:0] hit_next;
    logic [1:0] hit_reg;

    always_comb begin
        item_in             = '0;
        item_in.cmd         = s_tuser;
        item_in.entity_x    = s_tdata[0 +: POS_BITS];
        item_in.entity_y    = s_tdata[POS_BITS +: POS_BITS];
        item_in.speed_x     = s_tdata[2*POS_BITS +: VEL_BITS];
        item_in.speed_y     = s_tdata[2*POS_BITS + VEL_BITS +: VEL_BITS];
        item_in.tile_left   = s_tdata[2*POS_BITS + 2*VEL_BITS +: POS_BITS];
        item_in.tile_top    = s_tdata[3*POS_BITS + 2*VEL_BITS +: POS_BITS];
        item_in.tile_width  = s_tdata[4*POS_BITS + 2*VEL_BITS +: SIZE_BITS];
        item_in.tile_height = s_tdata[4*POS_BITS + 2*VEL_BITS + SIZE_BITS +: SIZE_BITS];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    atcr_resolve u_resolve (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .hit        (hit_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_in;
        end
        if (advance) begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.entity_width  <= RST_ENTITY_WIDTH;
            cfg_reg.entity_height <= RST_ENTITY_HEIGHT;
            cfg_reg.bounce_gain   <= RST_BOUNCE_GAIN;
            cfg_reg.wall_gap      <= RST_WALL_GAP;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_ENTITY_WIDTH:  cfg_reg.entity_width  <= cfg_wdata;
                REG_ENTITY_HEIGHT: cfg_reg.entity_height <= cfg_wdata;
                REG_BOUNCE_GAIN:   cfg_reg.bounce_gain   <= cfg_wdata;
                REG_WALL_GAP:      cfg_reg.wall_gap      <= cfg_wdata;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // The result shows the state register, which holds until the next advance.
    always_comb begin
        m_tdata = '0;
        m_tdata[0 +: POS_BITS]                   = state_reg.cur_x;
        m_tdata[POS_BITS +: POS_BITS]            = state_reg.cur_y;
        m_tdata[2*POS_BITS +: VEL_BITS]          = state_reg.cur_vx;
        m_tdata[2*POS_BITS + VEL_BITS +: VEL_BITS] = state_reg.cur_vy;
    end

    assign m_tuser  = hit_reg;
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/atcr_reflect.sv
// Velocity reflection: negates a velocity and scales it by the Q0.8 bounce gain,
// rounding the magnitude to nearest with halves away from zero. Uses atcr_pkg.
`default_nettype none

module atcr_reflect
    import atcr_pkg::*;
(
    input  vel_t                vel_in,
    input  logic [CFG_BITS-1:0] gain,
    output vel_t                vel_out
);

    localparam int MAG_W  = VEL_BITS + 1;
    localparam int PROD_W = MAG_W + CFG_BITS;

    logic signed [MAG_W-1:0] vel_wide;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    vel_t                    scaled;

    assign vel_wide = MAG_W'(vel_in);
    assign mag      = vel_in[VEL_BITS-1] ? MAG_W'(-vel_wide) : MAG_W'(vel_wide);
    assign prod     = PROD_W'(mag) * PROD_W'(gain) + (PROD_W'(1) << (CFG_BITS - 1));
    // The scaled magnitude never reaches the top of the velocity range.
    assign scaled   = prod[CFG_BITS +: VEL_BITS];
    assign vel_out  = vel_in[VEL_BITS-1] ? scaled : -scaled;

endmodule

`default_nettype wire

FILE: src/atcr_resolve.sv
// Combinational collision test and response for one request against the
// current entity state. Uses atcr_pkg and two atcr_reflect units.
`default_nettype none

module atcr_resolve
    import atcr_pkg::*;
(
    input  cfg_t       cfg,
    input  state_t     state_cur,
    input  item_t      item,
    output state_t     state_next,
    output logic [1:0] hit
);

    calc_t hw, eh, gap;
    calc_t cx, cy, sx, sy;
    calc_t tl, tt, tw, th, tr, tb;
    calc_t el, er, et, eb;
    calc_t dep_a, dep_b, dep_c, dep_d, dx, dy;
    calc_t push_left, push_right;
    logic  overlap, left_side, top_side;
    vel_t  vx_refl, vy_refl;

    assign hw  = calc_t'(cfg.entity_width) << (FRAC_BITS - 1);
    assign eh  = calc_t'(cfg.entity_height) << FRAC_BITS;
    assign gap = calc_t'(cfg.wall_gap);

    assign cx = calc_t'(state_cur.cur_x);
    assign cy = calc_t'(state_cur.cur_y);
    assign sx = calc_t'(state_cur.start_x);
    assign sy = calc_t'(state_cur.start_y);

    assign tl = calc_t'(item.tile_left);
    assign tt = calc_t'(item.tile_top);
    assign tw = calc_t'(item.tile_width);
    assign th = calc_t'(item.tile_height);
    assign tr = tl + tw;
    assign tb = tt + th;

    assign el = cx - hw;
    assign er = cx + hw;
    assign et = cy - eh;
    assign eb = cy;

    assign overlap = (er > tl) && (el < tr) && (eb > tt) && (et < tb);

    assign dep_a = er - tl;
    assign dep_b = tr - el;
    assign dep_c = eb - tt;
    assign dep_d = tb - et;
    assign dx    = (dep_a < dep_b) ? dep_a : dep_b;
    assign dy    = (dep_c < dep_d) ? dep_c : dep_d;

    // Centres are compared at twice their value so that no half is lost.
    assign left_side = (sx <<< 1) < ((tl <<< 1) + tw);
    assign top_side  = ((sy <<< 1) - eh) < ((tt <<< 1) + th);

    assign push_left  = tl - hw - gap;
    assign push_right = tr + hw + gap;

    atcr_reflect u_reflect_x (
        .vel_in  (state_cur.cur_vx),
        .gain    (cfg.bounce_gain),
        .vel_out (vx_refl)
    );

    atcr_reflect u_reflect_y (
        .vel_in  (state_cur.cur_vy),
        .gain    (cfg.bounce_gain),
        .vel_out (vy_refl)
    );

    always_comb begin
        state_next = state_cur;
        hit        = HIT_NONE;
        if (item.cmd == CMD_LOAD) begin
            state_next.cur_x   = item.entity_x;
            state_next.cur_y   = item.entity_y;
            state_next.cur_vx  = item.speed_x;
            state_next.cur_vy  = item.speed_y;
            state_next.start_x = item.entity_x;
            state_next.start_y = item.entity_y;
        end else if (overlap) begin
            if (dx < dy) begin
                hit = HIT_HORIZ;
                if (left_side) begin
                    state_next.cur_x = sat_pos(push_left);
                    if (state_cur.cur_vx > 0) begin
                        state_next.cur_vx = vx_refl;
                    end
                end else begin
                    state_next.cur_x = sat_pos(push_right);
                    if (state_cur.cur_vx < 0) begin
                        state_next.cur_vx = vx_refl;
                    end
                end
            end else begin
                hit = HIT_VERT;
                // A vertical response only turns the velocity round.
                if (top_side) begin
                    if (state_cur.cur_vy > 0) begin
                        state_next.cur_vy = vy_refl;
                    end
                end else begin
                    if (state_cur.cur_vy < 0) begin
                        state_next.cur_vy = vy_refl;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/atcr_checker.sv
// Port-level checker for the tile collision resolver, bound to the top level.
// Uses atcr_pkg for widths and hit codes.
`default_nettype none

module atcr_checker
    import atcr_pkg::*;
(
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic [OUT_DATA_BITS-1:0] m_tdata,
    input wire logic [1:0]               m_tuser,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A result only appears after a request was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a request");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // Only the three defined hit kinds are reported.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == HIT_NONE || m_tuser == HIT_HORIZ || m_tuser == HIT_VERT))
        else $error("undefined hit kind");

endmodule

bind aabb_tile_collision_resolve atcr_checker u_atcr_checker (.*);

`default_nettype wire
